// ----- hdl/rvwap_pkg.sv -----
// Package for the rolling volume-weighted average price block.
// Holds field widths, operation codes, the sequencer states and the divider status type.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rvwap_pkg;

    localparam int WINDOW_MAX_DEF = 256;
    localparam int PRICE_BITS_DEF = 24;

    localparam int OP_W         = 1;
    localparam int FILL_PRICE_W = 24;
    localparam int FILL_QTY_W   = 16;
    localparam int MID_W        = 32;
    localparam int AVG_W        = 32;
    localparam int CNT_W        = 9;
    localparam int FRAC_BITS    = 8;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_FILL  = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_CHECK,
        S_DIV,
        S_DONE
    } vwap_state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hdl/rvwap_div.sv -----
// Restoring divider producing a 32-bit quotient, one bit per cycle.
// The caller supplies a partial remainder already below the divisor.
// Depends on rvwap_pkg.
`timescale 1ns / 1ps

module rvwap_div
    import rvwap_pkg::*;
#(
    parameter int REM_W = FILL_QTY_W + CNT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REM_W-1:0] rem_init,
    input  logic [AVG_W-1:0] low_init,
    input  logic [REM_W-1:0] divisor,
    output logic [AVG_W-1:0] quotient,
    output div_stat_t        stat
);

    localparam int STEP_W = $clog2(AVG_W);

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [AVG_W-1:0]  quo_reg;
    logic [AVG_W-1:0]  quo_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic [REM_W:0]    trial;
    logic              last_step;

    assign trial     = {rem_reg, quo_reg[AVG_W-1]};
    assign last_step = busy_reg && (step_reg == STEP_W'(AVG_W - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = rem_init;
            quo_next  = low_init;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = REM_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[AVG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = REM_W'(trial);
                quo_next = {quo_reg[AVG_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            busy_next = !last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = last_step;

endmodule

// ----- hdl/rolling_vwap_last_n_fills.sv -----
// Rolling volume-weighted average price over the most recent fills, kept in a ring memory.
// Steps: S_IDLE takes a beat, S_READ reads the entry to evict, S_UPDATE adjusts the sums,
// S_CHECK picks fallback, saturation or division, S_DIV runs the 32-step serial divider,
// S_DONE loads the output once it is free, and only then is a new beat taken.
// Reset (asynchronous, active low) empties the history and sets the window to 256.
`timescale 1ns / 1ps

module rolling_vwap_last_n_fills
    import rvwap_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // fill_price [23:0], fill_qty [39:24], fallback mid [71:40]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // average_price [31:0], fills_in_window [40:32], zero padding above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // used_mid
    output logic                  m_axis_tuser
);

    localparam int PRICE_W = (PRICE_BITS < FILL_PRICE_W) ? PRICE_BITS : FILL_PRICE_W;
    localparam int ENT_W   = PRICE_W + FILL_QTY_W;
    localparam int PROD_W  = PRICE_W + FILL_QTY_W;
    localparam int VSUM_W  = PROD_W + CNT_W;
    localparam int QSUM_W  = FILL_QTY_W + CNT_W;
    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SHIFT   = AVG_W - FRAC_BITS;
    localparam int PAD_W   = OUT_DATA_W - AVG_W - CNT_W;

    vwap_state_t state_reg;
    vwap_state_t state_next;

    logic [ENT_W-1:0] ring_mem [WINDOW_MAX];
    logic [ENT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  window_reg;
    logic [CNT_W-1:0]  window_next;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [VSUM_W-1:0] vsum_reg;
    logic [VSUM_W-1:0] vsum_next;
    logic [QSUM_W-1:0] qsum_reg;
    logic [QSUM_W-1:0] qsum_next;

    logic [OP_W-1:0]       op_reg;
    logic [PRICE_W-1:0]    price_reg;
    logic [FILL_QTY_W-1:0] qty_reg;
    logic [MID_W-1:0]      mid_reg;
    logic [PROD_W-1:0]     new_prod_reg;

    logic [AVG_W-1:0] res_avg_reg;
    logic             res_used_reg;
    logic             res_div_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [AVG_W-1:0] out_avg_reg;
    logic             out_used_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic              in_accept;
    logic              cfg_accept;
    logic [CNT_W-1:0]  win_eff;
    logic              evict;
    logic              do_fill;
    logic [AW:0]       old_sum;
    logic [AW-1:0]     old_idx;
    logic [PROD_W-1:0] old_prod;
    logic              fallback;
    logic              saturate;
    logic              mem_re;
    logic              upd_en;
    logic              check_en;
    logic              div_start;
    logic              out_load;

    logic [AVG_W-1:0]  div_quo;
    div_stat_t         div_stat;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign win_eff = (32'(window_reg) > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : window_reg;
    assign evict   = count_reg >= win_eff;
    assign do_fill = (op_reg == OP_FILL) && (win_eff != '0);

    assign old_sum  = {1'b0, head_reg} + ((AW + 1)'(WINDOW_MAX) - (AW + 1)'(win_eff));
    assign old_idx  = (old_sum >= (AW + 1)'(WINDOW_MAX)) ?
                      AW'(old_sum - (AW + 1)'(WINDOW_MAX)) : AW'(old_sum);
    assign old_prod = rd_data_reg[PRICE_W-1:0] * rd_data_reg[ENT_W-1:PRICE_W];

    assign fallback = (count_reg == '0) || (qsum_reg == '0);
    assign saturate = (vsum_reg >> SHIFT) >= VSUM_W'(qsum_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_CHECK;
            S_CHECK:  state_next = (fallback || saturate) ? S_DONE : S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        cfg_ready     = 1'b0;
        mem_re        = 1'b0;
        upd_en        = 1'b0;
        check_en      = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = !cfg_valid;
                cfg_ready     = 1'b1;
            end
            S_READ:   mem_re   = 1'b1;
            S_UPDATE: upd_en   = 1'b1;
            S_CHECK:
            begin
                check_en  = 1'b1;
                div_start = !fallback && !saturate;
            end
            S_DONE:   out_load = !out_valid_reg || m_axis_tready;
            default:  s_axis_tready = 1'b0;
        endcase
    end

    always_comb
    begin
        window_next = window_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        vsum_next   = vsum_reg;
        qsum_next   = qsum_reg;
        if (cfg_accept)
        begin
            window_next = cfg_data;
            head_next   = '0;
            count_next  = '0;
            vsum_next   = '0;
            qsum_next   = '0;
        end
        else if (upd_en && do_fill)
        begin
            vsum_next = vsum_reg + VSUM_W'(new_prod_reg)
                        - (evict ? VSUM_W'(old_prod) : VSUM_W'(0));
            qsum_next = qsum_reg + QSUM_W'(qty_reg)
                        - (evict ? QSUM_W'(rd_data_reg[ENT_W-1:PRICE_W]) : QSUM_W'(0));
            count_next = evict ? count_reg : count_reg + 1'b1;
            head_next  = (head_reg == AW'(WINDOW_MAX - 1)) ? '0 : head_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            vsum_reg      <= '0;
            qsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            vsum_reg      <= vsum_next;
            qsum_reg      <= qsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= s_axis_tuser;
            price_reg <= s_axis_tdata[PRICE_W-1:0];
            qty_reg   <= s_axis_tdata[FILL_PRICE_W +: FILL_QTY_W];
            mid_reg   <= s_axis_tdata[FILL_PRICE_W + FILL_QTY_W +: MID_W];
        end
        if (mem_re)
        begin
            new_prod_reg <= price_reg * qty_reg;
        end
        if (check_en)
        begin
            res_div_reg  <= !fallback && !saturate;
            res_used_reg <= fallback;
            res_avg_reg  <= fallback ? mid_reg : '1;
        end
        if (out_load)
        begin
            out_avg_reg  <= res_div_reg ? div_quo : res_avg_reg;
            out_used_reg <= res_used_reg;
            out_cnt_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_en && do_fill)
        begin
            ring_mem[head_reg] <= {qty_reg, price_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= ring_mem[old_idx];
        end
    end

    rvwap_div #(
        .REM_W (QSUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (QSUM_W'(vsum_reg >> SHIFT)),
        .low_init ({vsum_reg[SHIFT-1:0], {FRAC_BITS{1'b0}}}),
        .divisor  (qsum_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_cnt_reg, out_avg_reg};
    assign m_axis_tuser  = out_used_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("Divider started while still busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("Divider finished outside the division state.");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= win_eff)
        else $error("Fill count exceeds the effective window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((vsum_reg == '0) && (qsum_reg == '0)))
        else $error("Running sums are not zero with an empty history.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid)
        else $error("Loaded result is not presented on the output.");

endmodule
